// ===== hw/rtl/fqr_pkg.sv =====
// shared types and codes for the positional-removal queue
package fqr_pkg;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_PEEK   = 2'd3
  } op_t;

  // per-cell controls driven by the top level
  typedef struct packed {
    logic load;   // take the incoming item
    logic shift;  // take the neighbour's entry (closing up)
    logic sel;    // drive the entry onto the read bus
  } cell_ctl_t;

endpackage

// ===== hw/rtl/fqr_if.sv =====
// request and result channel interfaces of the positional-removal queue
interface fqr_in_if #(
  parameter int ITEM_W = 32,
  parameter int CNT_W  = 5
);
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [ITEM_W-1:0] item_in;
  logic [CNT_W-1:0]  position;

  modport source (output valid, output op, output item_in, output position, input ready);
  modport sink   (input valid, input op, input item_in, input position, output ready);
endinterface

interface fqr_out_if #(
  parameter int ITEM_W = 32,
  parameter int CNT_W  = 5
);
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ITEM_W-1:0] item_out;
  logic [CNT_W-1:0]  count;
  logic              empty_res;

  modport source (output valid, output ok, output item_out, output count, output empty_res,
                  input ready);
  modport sink   (input valid, input ok, input item_out, input count, input empty_res,
                  output ready);
endinterface

// ===== hw/rtl/fqr_cell.sv =====
// one storage cell of the queue chain
module fqr_cell
  import fqr_pkg::*;
#(
  parameter int ITEM_W = 32
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [ITEM_W-1:0] item_in,
  input  logic [ITEM_W-1:0] nbr_data,
  output logic [ITEM_W-1:0] data_o,
  output logic [ITEM_W-1:0] rd_data
);

  logic [ITEM_W-1:0] data_r;
  logic [ITEM_W-1:0] data_nxt;

  always_comb begin
    priority if (ctl.load) begin
      data_nxt = item_in;
    end else if (ctl.shift) begin
      data_nxt = nbr_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o  = data_r;
  assign rd_data = ctl.sel ? data_r : '0;

endmodule

// ===== hw/rtl/fifo_queue_with_positional_removal_core.sv =====
// top level: bounded queue with dequeue, removal and peek at a position
//
// in_ch carries one request per transaction: op (enqueue, dequeue head,
// remove at position, peek at position), item_in and a 1-based position.
// out_ch returns exactly one result per request, in order: ok, the removed
// or peeked item (zero on enqueue or failure), the count after the request
// and an empty flag.
// Entries sit in a row of DEPTH cells, head in cell 0. A removal makes every
// cell behind the gap take its neighbour's entry in the same cycle.
// The result is registered and valid in the cycle after the request transaction, and one
// request is taken every cycle while out_ch keeps up. The cycle is set by the
// position compare and the AND-OR read across all cells.
// A result register parts the channels: a new request is taken while the
// previous result is being taken in the same cycle. When the receiver stalls
// the result holds and in_ch.ready drops until it is taken.
// Reset empties the queue and clears the result valid flag; entry contents are
// left as they are and are never read before being written.
module fifo_queue_with_positional_removal_core
  import fqr_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int ITEM_W = 32,
  parameter int CNT_W  = 5
) (
  input  logic      clk,
  input  logic      rst_n,
  fqr_in_if.sink    in_ch,
  fqr_out_if.source out_ch
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_ok_r, out_empty_r;
  logic [ITEM_W-1:0] out_item_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              acc;
  op_t               op;
  logic              pos_ok;
  logic [CNT_W-1:0]  idx;
  logic              do_enq, do_take, do_peek, res_ok;
  logic [ITEM_W-1:0] rd_bus;

  cell_ctl_t         ctl   [DEPTH];
  logic [ITEM_W-1:0] data  [DEPTH];
  logic [ITEM_W-1:0] rd    [DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign op          = op_t'(in_ch.op);
  assign pos_ok      = (in_ch.position != '0) && (in_ch.position <= cnt_r);
  // dequeue reads and removes at the head
  assign idx         = (op == OP_DEQ) ? '0 : in_ch.position - CNT_W'(1);

  always_comb begin
    do_enq  = 1'b0;
    do_take = 1'b0;
    do_peek = 1'b0;
    unique case (op)
      OP_ENQ:    do_enq  = acc && (cnt_r < DEPTH_C);
      OP_DEQ:    do_take = acc && (cnt_r != '0);
      OP_REMOVE: do_take = acc && pos_ok;
      OP_PEEK:   do_peek = acc && pos_ok;
      default:   do_peek = 1'b0;
    endcase
  end

  assign res_ok = do_enq || do_take || do_peek;

  always_comb begin
    priority if (do_enq) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_take) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctl[i].load  = do_enq && (cnt_r == CNT_W'(i));
    assign ctl[i].shift = do_take && (CNT_W'(i) >= idx) && (CNT_W'(i + 1) < cnt_r);
    assign ctl[i].sel   = (idx == CNT_W'(i));

    if (i == DEPTH - 1) begin : g_last
      fqr_cell #(.ITEM_W(ITEM_W)) u_cell (
        .clk      (clk),
        .ctl      (ctl[i]),
        .item_in  (in_ch.item_in),
        .nbr_data (data[i]),
        .data_o   (data[i]),
        .rd_data  (rd[i])
      );
    end else begin : g_mid
      fqr_cell #(.ITEM_W(ITEM_W)) u_cell (
        .clk      (clk),
        .ctl      (ctl[i]),
        .item_in  (in_ch.item_in),
        .nbr_data (data[i+1]),
        .data_o   (data[i]),
        .rd_data  (rd[i])
      );
    end
  end

  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_ok_r    <= res_ok;
      out_item_r  <= (do_take || do_peek) ? rd_bus : '0;
      out_count_r <= cnt_nxt;
      out_empty_r <= (cnt_nxt == '0);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.ok        = out_ok_r;
  assign out_ch.item_out  = out_item_r;
  assign out_ch.count     = out_count_r;
  assign out_ch.empty_res = out_empty_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above depth");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_enq |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("enqueue did not raise the count");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_count_r == '0)))
    else $error("empty flag disagrees with count");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_item_r == '0))
    else $error("failed request returned a nonzero item");

endmodule
